// ----- src/srws_pkg.sv -----
// package for the selective-repeat window sender
// holds register defaults, register indexes, action and result codes and the sequencer states
// no dependencies
package srws_pkg;

	// ring depth default and sequence number width
	localparam int WINDOW_DEF = 16;
	localparam int SEQ_BITS   = 16;
	localparam logic [15:0] SEQ_MASK =
		(SEQ_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << SEQ_BITS) - 32'd1);

	// configuration register indexes (byte address is four times the index)
	localparam logic [2:0] REG_PACKET_COUNT  = 3'd0;
	localparam logic [2:0] REG_LAST_BYTES    = 3'd1;
	localparam logic [2:0] REG_PAYLOAD_BYTES = 3'd2;
	localparam logic [2:0] REG_TIMEOUT       = 3'd3;
	localparam logic [2:0] REG_WINDOW        = 3'd4;

	// configuration reset values
	localparam logic [15:0] PACKET_COUNT_RST = 16'd1;
	localparam logic [9:0]  LAST_BYTES_RST   = 10'd960;
	localparam logic [9:0]  PAYLOAD_RST      = 10'd960;
	localparam logic [15:0] TIMEOUT_RST      = 16'd20;
	localparam logic [4:0]  WINDOW_RST       = 5'd16;

	// input actions
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_ACK   = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_SEND   = 2'd0;
	localparam logic [1:0] KIND_RESEND = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_APPLY  = 7'b0000010,
		ST_ADV    = 7'b0000100,
		ST_RS_RD  = 7'b0001000,
		ST_RS_CHK = 7'b0010000,
		ST_NS     = 7'b0100000,
		ST_STAT   = 7'b1000000
	} state_t;

endpackage

// ----- src/selective_repeat_window_sender_top.sv -----
// top level of the selective-repeat window sender: stream ports, register port, sequencer
// and the send-time memory
// depends on srws_pkg
//
// Each input transaction (start, ack or tick) produces one or more result transactions:
// first sends and timeout resends in sequence order, then one status result carrying tlast.
// The block takes a new input item only once it is idle again, after the whole pass for the
// last one: the sequencer moves the base over acknowledged slots, reads and checks each
// in-flight packet for timeout, then sends new packets up to the window edge, walking the
// single-ported send-time memory one slot at a time. An item that arrives while no transfer
// is running goes straight to its status result. Output stalls hold the pass.
// The send-time memory needs no clearing: every entry is written when its packet is sent.
module selective_repeat_window_sender_top
	import srws_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // ack_seq [15:0]
	input  logic [1:0]  s_tuser,   // action [1:0]
	// stream output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // seq [15:0], length_bytes [25:16], byte_offset [51:26],
	                               // window_base [67:52], done_res [68], zero fill
	output logic [1:0]  m_tuser,   // kind [1:0]
	output logic        m_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SW = $clog2(WINDOW);
	localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW - 1);

	// configuration registers
	logic [15:0] packet_count_q;
	logic [9:0]  last_bytes_q;
	logic [9:0]  payload_bytes_q;
	logic [15:0] timeout_q;
	logic [4:0]  window_limit_q;
	logic [2:0]  reg_idx;
	logic        reg_wr;

	// transfer state
	state_t        state_q;
	logic [1:0]    act_q;
	logic [15:0]   ack_q;
	logic [15:0]   window_base_q;
	logic [SW-1:0] base_slot_q;
	logic [15:0]   next_unsent_q;
	logic [SW-1:0] nu_slot_q;
	logic [31:0]   tick_q;
	logic          running_q;
	logic [WINDOW-1:0] acked_q;
	logic [15:0]   edge_q;
	logic [15:0]   lim_q;
	logic [15:0]   s_q;
	logic [SW-1:0] slot_q;

	// send-time memory
	logic [31:0]   sent_mem [WINDOW];
	logic [31:0]   rd_data_q;
	logic          mem_we;
	logic [SW-1:0] mem_waddr;

	// output register
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [15:0] out_seq_q;
	logic [9:0]  out_len_q;
	logic [25:0] out_off_q;
	logic [15:0] out_base_q;
	logic        out_done_q;
	logic        out_last_q;

	// combinational helpers
	logic          can_emit;
	logic          emit;
	logic [1:0]    emit_kind;
	logic [15:0]   emit_s;
	logic          emit_status;
	logic [15:0]   ack_m;
	logic          ack_in_win;
	logic [15:0]   ack_diff;
	logic [SW:0]   ack_sum;
	logic [SW-1:0] ack_slot;
	logic [16:0]   eff_win;
	logic [16:0]   edge_sum;
	logic [15:0]   edge_c;
	logic [15:0]   lim_c;
	logic          base_step;
	logic          timed_out;
	logic          done_now;
	logic [SW-1:0] base_slot_inc;
	logic [SW-1:0] slot_inc;
	logic [SW-1:0] nu_slot_inc;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_count_q  <= PACKET_COUNT_RST;
			last_bytes_q    <= LAST_BYTES_RST;
			payload_bytes_q <= PAYLOAD_RST;
			timeout_q       <= TIMEOUT_RST;
			window_limit_q  <= WINDOW_RST;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_PACKET_COUNT:  packet_count_q  <= pwdata[15:0];
				REG_LAST_BYTES:    last_bytes_q    <= pwdata[9:0];
				REG_PAYLOAD_BYTES: payload_bytes_q <= pwdata[9:0];
				REG_TIMEOUT:       timeout_q       <= pwdata[15:0];
				REG_WINDOW:        window_limit_q  <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PACKET_COUNT:  prdata = {16'd0, packet_count_q};
			REG_LAST_BYTES:    prdata = {22'd0, last_bytes_q};
			REG_PAYLOAD_BYTES: prdata = {22'd0, payload_bytes_q};
			REG_TIMEOUT:       prdata = {16'd0, timeout_q};
			REG_WINDOW:        prdata = {27'd0, window_limit_q};
			default:           prdata = 32'd0;
		endcase
	end

	// ring slot increments
	assign base_slot_inc = (base_slot_q == SLOT_LAST) ? '0 : base_slot_q + 1'b1;
	assign slot_inc      = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
	assign nu_slot_inc   = (nu_slot_q == SLOT_LAST) ? '0 : nu_slot_q + 1'b1;

	// ack slot: the ack lies less than one window above the base
	assign ack_m      = ack_q & SEQ_MASK;
	assign ack_in_win = (ack_m >= window_base_q) && (ack_m < next_unsent_q);
	assign ack_diff   = ack_m - window_base_q;
	assign ack_sum    = {1'b0, base_slot_q} + {1'b0, ack_diff[SW-1:0]};
	assign ack_slot   = (ack_sum >= (SW+1)'(WINDOW)) ?
		SW'(ack_sum - (SW+1)'(WINDOW)) : ack_sum[SW-1:0];

	// window edge and resend limit
	always_comb begin
		if (window_limit_q == 5'd0)
			eff_win = 17'd1;
		else if (17'(window_limit_q) > 17'(WINDOW))
			eff_win = 17'(WINDOW);
		else
			eff_win = 17'(window_limit_q);
	end
	assign edge_sum = {1'b0, window_base_q} + eff_win;
	assign edge_c   = (edge_sum > {1'b0, packet_count_q}) ? packet_count_q : edge_sum[15:0];
	assign lim_c    = (edge_c < next_unsent_q) ? edge_c : next_unsent_q;

	assign base_step = (window_base_q < next_unsent_q) && acked_q[base_slot_q];
	assign done_now  = (window_base_q >= packet_count_q);
	assign timed_out = !acked_q[slot_q] && ((tick_q - rd_data_q) > {16'd0, timeout_q});

	// result emission
	assign can_emit = !out_valid_q || m_tready;
	always_comb begin
		emit        = 1'b0;
		emit_kind   = KIND_STATUS;
		emit_s      = next_unsent_q;
		emit_status = 1'b0;
		case (state_q)
			ST_RS_CHK: begin
				emit      = timed_out && can_emit;
				emit_kind = KIND_RESEND;
				emit_s    = s_q;
			end
			ST_NS: begin
				emit      = (next_unsent_q < edge_q) && can_emit;
				emit_kind = KIND_SEND;
			end
			ST_STAT: begin
				emit        = can_emit;
				emit_status = 1'b1;
			end
			default: ;
		endcase
	end

	// send-time memory write port
	assign mem_we    = emit && !emit_status;
	assign mem_waddr = (state_q == ST_RS_CHK) ? slot_q : nu_slot_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			sent_mem[mem_waddr] <= tick_q;
		if (state_q == ST_RS_RD)
			rd_data_q <= sent_mem[slot_q];
	end

	// input capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_q <= s_tuser;
			ack_q <= s_tdata;
		end
	end
	assign s_tready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_base_q <= '0;
			base_slot_q   <= '0;
			next_unsent_q <= '0;
			nu_slot_q     <= '0;
			tick_q        <= '0;
			running_q     <= 1'b0;
			acked_q       <= '0;
			edge_q        <= '0;
			lim_q         <= '0;
			s_q           <= '0;
			slot_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_APPLY;
				end
				// apply the action, then run the pass while a transfer is live
				ST_APPLY: begin
					if (act_q == ACT_START) begin
						window_base_q <= '0;
						base_slot_q   <= '0;
						next_unsent_q <= '0;
						nu_slot_q     <= '0;
						tick_q        <= '0;
						acked_q       <= '0;
						running_q     <= 1'b1;
						state_q       <= ST_ADV;
					end else begin
						if (act_q == ACT_TICK)
							tick_q <= tick_q + 32'd1;
						if (act_q == ACT_ACK && running_q && ack_in_win)
							acked_q[ack_slot] <= 1'b1;
						state_q <= running_q ? ST_ADV : ST_STAT;
					end
				end
				// move the base over acknowledged slots, one a cycle
				ST_ADV: begin
					if (base_step) begin
						acked_q[base_slot_q] <= 1'b0;
						window_base_q        <= window_base_q + 16'd1;
						base_slot_q          <= base_slot_inc;
					end else if (done_now) begin
						running_q <= 1'b0;
						state_q   <= ST_STAT;
					end else begin
						edge_q  <= edge_c;
						lim_q   <= lim_c;
						s_q     <= window_base_q;
						slot_q  <= base_slot_q;
						state_q <= ST_RS_RD;
					end
				end
				// timeout walk: read the send time of the slot
				ST_RS_RD: begin
					state_q <= (s_q < lim_q) ? ST_RS_CHK : ST_NS;
				end
				// resend if too old, else move on
				ST_RS_CHK: begin
					if (!timed_out || can_emit) begin
						s_q     <= s_q + 16'd1;
						slot_q  <= slot_inc;
						state_q <= ST_RS_RD;
					end
				end
				// first sends up to the window edge
				ST_NS: begin
					if (next_unsent_q >= edge_q) begin
						state_q <= ST_STAT;
					end else if (can_emit) begin
						acked_q[nu_slot_q] <= 1'b0;
						next_unsent_q      <= next_unsent_q + 16'd1;
						nu_slot_q          <= nu_slot_inc;
					end
				end
				ST_STAT: begin
					if (can_emit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= emit_kind;
			out_base_q <= window_base_q;
			out_last_q <= emit_status;
			if (emit_status) begin
				out_seq_q  <= '0;
				out_len_q  <= '0;
				out_off_q  <= '0;
				out_done_q <= done_now;
			end else begin
				out_seq_q  <= emit_s & SEQ_MASK;
				out_len_q  <= ({1'b0, emit_s} + 17'd1 == {1'b0, packet_count_q}) ?
					last_bytes_q : payload_bytes_q;
				out_off_q  <= 26'(emit_s) * 26'(payload_bytes_q);
				out_done_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'd0, out_done_q, out_base_q, out_off_q, out_len_q, out_seq_q};

endmodule

// ----- bench/tb_selective_repeat_window_sender_top.sv -----
`timescale 1ns / 100ps
// self-checking bench for the selective-repeat window sender: directed and random start, ack
// and tick streams against an in-bench window predictor; depends on srws_pkg and the top level
module tb_selective_repeat_window_sender_top;
	import srws_pkg::*;

	localparam int WIN          = WINDOW_DEF;
	localparam int LATENCY      = 4 + 4 * WIN + 8;
	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 30;
	// action code the block does not use
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] ack_seq;
	} tx_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] seq;
		logic [9:0]  len;
		logic [25:0] off;
		logic [15:0] base;
		logic        done;
		logic        last;
	} result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;    // ack_seq [15:0]
	logic [1:0]  s_tuser  = '0;    // action [1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;          // seq [15:0], length_bytes [25:16], byte_offset [51:26],
	                               // window_base [67:52], done_res [68], zero fill
	logic [1:0]  m_tuser;          // kind [1:0]
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor copy of the registers and the window state
	logic [15:0] p_count   = PACKET_COUNT_RST;
	logic [9:0]  p_last    = LAST_BYTES_RST;
	logic [9:0]  p_payload = PAYLOAD_RST;
	logic [15:0] p_timeout = TIMEOUT_RST;
	logic [4:0]  p_window  = WINDOW_RST;
	int unsigned p_base    = 0;
	int unsigned p_next    = 0;
	bit [31:0]   p_clock   = '0;
	bit          p_running = 1'b0;
	bit [WIN-1:0] p_acked  = '0;
	bit [31:0]   p_sent [WIN];

	tx_item_t pending_items [$];
	result_t  exp_results [$];
	tx_item_t bus_item;
	result_t  mon_got, mon_want;

	int errors         = 0;
	int items_in       = 0;
	int results_seen   = 0;
	int resends        = 0;
	int transfers_done = 0;
	int reg_writes     = 0;
	int gap_left       = 0;
	int burst_left     = 0;
	int rx_mode        = 0;
	int rx_cycle       = 0;
	int hold_left      = 0;
	bit hold_req       = 1'b0;
	int idle_cycles    = 0;

	selective_repeat_window_sender_top #(.WINDOW(WIN)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
				results_seen);
	endtask

	// queue one first send or resend of packet s
	function automatic void push_send(input logic [1:0] kind, input int unsigned s);
		result_t r;
		r.kind = kind;
		r.seq  = 16'(s);
		r.len  = (s + 1 == p_count) ? p_last : p_payload;
		r.off  = 26'(s * p_payload);
		r.base = 16'(p_base);
		r.done = 1'b0;
		r.last = 1'b0;
		exp_results.push_back(r);
	endfunction

	// apply one accepted transaction to the window state and queue the results it causes
	task automatic predict_results(input tx_item_t it);
		int unsigned w, win_edge, lim, s, slot;
		bit [31:0] age;
		result_t st;
		case (it.action)
			ACT_START: begin
				p_base    = 0;
				p_next    = 0;
				p_clock   = '0;
				p_acked   = '0;
				p_sent    = '{default: '0};
				p_running = 1'b1;
			end
			ACT_TICK: p_clock = p_clock + 1;
			ACT_ACK: begin
				if (p_running && it.ack_seq >= p_base && it.ack_seq < p_next)
					p_acked[it.ack_seq % WIN] = 1'b1;
			end
			default: ;
		endcase
		if (p_running) begin
			// slide the base over acknowledged slots
			while (p_base < p_next && p_acked[p_base % WIN]) begin
				p_acked[p_base % WIN] = 1'b0;
				p_base++;
			end
			if (p_base >= p_count) begin
				p_running = 1'b0;
				transfers_done++;
			end else begin
				w = (p_window < 1) ? 1 : ((p_window > WIN) ? WIN : p_window);
				win_edge = p_base + w;
				if (win_edge > p_count)
					win_edge = p_count;
				lim = (win_edge < p_next) ? win_edge : p_next;
				// timeout resends inside the current window
				for (s = p_base; s < lim; s++) begin
					slot = s % WIN;
					age  = p_clock - p_sent[slot];
					if (!p_acked[slot] && age > p_timeout) begin
						p_sent[slot] = p_clock;
						push_send(KIND_RESEND, s);
						resends++;
					end
				end
				// new packets up to the window edge
				for (s = p_next; s < win_edge; s++) begin
					slot = s % WIN;
					p_acked[slot] = 1'b0;
					p_sent[slot]  = p_clock;
					push_send(KIND_SEND, s);
				end
				if (win_edge > p_next)
					p_next = win_edge;
			end
		end
		st.kind = KIND_STATUS;
		st.seq  = '0;
		st.len  = '0;
		st.off  = '0;
		st.base = 16'(p_base);
		st.done = (p_base >= p_count);
		st.last = 1'b1;
		exp_results.push_back(st);
	endtask

	// stream driver: bursts of transactions separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_results(bus_item);
				items_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					bus_item = pending_items.pop_front();
					s_tdata  <= bus_item.ack_seq;
					s_tuser  <= bus_item.action;
					s_tvalid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				mon_got.kind = m_tuser;
				mon_got.seq  = m_tdata[15:0];
				mon_got.len  = m_tdata[25:16];
				mon_got.off  = m_tdata[51:26];
				mon_got.base = m_tdata[67:52];
				mon_got.done = m_tdata[68];
				mon_got.last = m_tlast;
				results_seen++;
				if (exp_results.size() == 0) begin
					report_mismatch("result with nothing outstanding, kind", mon_got.kind, 0);
				end else begin
					mon_want = exp_results.pop_front();
					if (mon_got.kind !== mon_want.kind)
						report_mismatch("kind", mon_got.kind, mon_want.kind);
					if (mon_got.seq !== mon_want.seq)
						report_mismatch("seq", mon_got.seq, mon_want.seq);
					if (mon_got.len !== mon_want.len)
						report_mismatch("length_bytes", mon_got.len, mon_want.len);
					if (mon_got.off !== mon_want.off)
						report_mismatch("byte_offset", mon_got.off, mon_want.off);
					if (mon_got.base !== mon_want.base)
						report_mismatch("window_base", mon_got.base, mon_want.base);
					if (mon_got.done !== mon_want.done)
						report_mismatch("done_res", mon_got.done, mon_want.done);
					if (mon_got.last !== mon_want.last)
						report_mismatch("tlast", mon_got.last, mon_want.last);
				end
			end
			// long hold-off on request, otherwise a changing stall mode
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				if (rx_cycle == 0) begin
					rx_mode  = $urandom_range(0, 2);
					rx_cycle = $urandom_range(20, 80);
				end else begin
					rx_cycle--;
				end
				case (rx_mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic push_item(input logic [1:0] action, input logic [15:0] ack_seq);
		tx_item_t it;
		it.action  = action;
		it.ack_seq = ack_seq;
		while (pending_items.size() >= 2)
			@(negedge clk);
		pending_items.push_back(it);
	endtask

	// wait until the block has drained every outstanding result
	task automatic settle_block();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || exp_results.size() != 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	// register write followed by a read back, predictor copy updated at the write
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] kept;
		logic [31:0] rd;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_PACKET_COUNT:  begin kept = value & 32'hFFFF; p_count   = kept[15:0]; end
			REG_LAST_BYTES:    begin kept = value & 32'h3FF;  p_last    = kept[9:0];  end
			REG_PAYLOAD_BYTES: begin kept = value & 32'h3FF;  p_payload = kept[9:0];  end
			REG_TIMEOUT:       begin kept = value & 32'hFFFF; p_timeout = kept[15:0]; end
			default:           begin kept = value & 32'h1F;   p_window  = kept[4:0];  end
		endcase
		reg_writes++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== kept)
			report_mismatch("register read back", rd, kept);
	endtask

	task automatic set_profile(input logic [31:0] count, input logic [31:0] last_len,
			input logic [31:0] payload, input logic [31:0] timeout, input logic [31:0] window);
		settle_block();
		write_reg(REG_PACKET_COUNT, count);
		write_reg(REG_LAST_BYTES, last_len);
		write_reg(REG_PAYLOAD_BYTES, payload);
		write_reg(REG_TIMEOUT, timeout);
		write_reg(REG_WINDOW, window);
	endtask

	// mostly in-window acks and ticks, with some stray acks, unused actions and restarts
	task automatic random_phase(input int n);
		int counted;
		int r;
		logic [15:0] ack;
		counted = 0;
		push_item(ACT_START, 16'($urandom));
		while (counted < n) begin
			r = $urandom_range(0, 99);
			if (!p_running) begin
				push_item(ACT_START, 16'($urandom));
			end else if (r < 55 && p_next > p_base) begin
				push_item(ACT_ACK, 16'($urandom_range(p_base, p_next - 1)));
			end else if (r < 65) begin
				case ($urandom_range(0, 2))
					0:       ack = 16'($urandom);
					1:       ack = 16'(p_next + $urandom_range(0, 2));
					default: ack = (p_base > 0) ? 16'(p_base - 1) : 16'hFFFF;
				endcase
				push_item(ACT_ACK, ack);
			end else if (r < 92) begin
				push_item(ACT_TICK, 16'($urandom));
			end else if (r < 97) begin
				push_item(ACT_NONE, 16'($urandom));
			end else begin
				push_item(ACT_START, 16'($urandom));
			end
			counted++;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// idle behaviour with the reset configuration, then a one-packet transfer
		push_item(ACT_TICK, 16'd0);
		push_item(ACT_ACK, 16'd5);
		push_item(ACT_NONE, 16'hFFFF);
		push_item(ACT_START, 16'd0);
		push_item(ACT_ACK, 16'd0);
		push_item(ACT_ACK, 16'd0);
		push_item(ACT_TICK, 16'd0);

		// a zero packet count reads as done straight away
		settle_block();
		write_reg(REG_PACKET_COUNT, 32'd0);
		push_item(ACT_START, 16'd0);
		push_item(ACT_TICK, 16'd0);

		// window register below range, zero timeout, extreme lengths
		set_profile(20, 1, 1023, 0, 0);
		push_item(ACT_START, 16'd0);
		push_item(ACT_TICK, 16'd0);
		push_item(ACT_ACK, 16'hFFFF);
		push_item(ACT_ACK, 16'd0);
		push_item(ACT_NONE, 16'd0);
		push_item(ACT_TICK, 16'd0);
		push_item(ACT_ACK, 16'd1);

		// window shrinks with packets in flight, then a register above range
		set_profile(40, 1023, 960, 2, 16);
		push_item(ACT_START, 16'd0);
		push_item(ACT_ACK, 16'd3);
		push_item(ACT_ACK, 16'd0);
		settle_block();
		write_reg(REG_WINDOW, 32'd2);
		push_item(ACT_TICK, 16'd0);
		push_item(ACT_TICK, 16'd0);
		push_item(ACT_TICK, 16'd0);
		settle_block();
		write_reg(REG_WINDOW, 32'd31);
		push_item(ACT_TICK, 16'd0);

		// random traffic over several register settings
		set_profile(12, 100, 960, 3, 4);
		hold_req = 1'b1;
		random_phase(50);
		set_profile(65535, 1023, 1023, 65535, 16);
		random_phase(25);
		set_profile(30, 1, 1, 1, 1);
		random_phase(45);
		set_profile(9, 513, 0, 2, 31);
		random_phase(35);
		set_profile(25, 777, 341, 4, 8);
		random_phase(65);

		settle_block();
		$display("run: %0d input transactions, %0d result transactions, %0d resends",
			items_in, results_seen, resends);
		$display("run: %0d transfers completed over %0d register writes, %0d mismatches",
			transfers_done, reg_writes, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- selective_repeat_window_sender_top.f -----
src/srws_pkg.sv
src/selective_repeat_window_sender_top.sv
bench/tb_selective_repeat_window_sender_top.sv
